@@ rtl/core/ajd_pkg.sv @@
// Shared constants and types for the accelerometer jump detector.
`timescale 1ns / 1ps
package ajd_pkg;

    localparam int WINDOW     = 5;
    localparam int RING_DEPTH = 2 * WINDOW;

    localparam int SAMPLE_W = 14;
    localparam int THRESH_W = 13;
    localparam int NUM_AXES = 3;

    // window sum spans +/- WINDOW * 2^(SAMPLE_W-1)
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
    localparam int DIFF_W  = SUM_W + 1;
    localparam int LIMIT_W = THRESH_W + $clog2(WINDOW + 1);
    localparam int CMP_W   = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;

    localparam int S_TDATA_W = ((NUM_AXES * SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(512);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic [THRESH_W-1:0]        thresh_t;
    typedef logic [LIMIT_W-1:0]         limit_t;

    function automatic limit_t limit_of(input thresh_t thr);
        limit_of = LIMIT_W'(thr) * LIMIT_W'(WINDOW);
    endfunction

endpackage

@@ rtl/core/accel_jump_detector_core.sv @@
// Top level of the accelerometer step-change (jump) detector.
`timescale 1ns / 1ps
// Usage:
//   s_ channel: one word per three-axis sample, x/y/z in 1/1024 g.
//   m_ channel: one word per sample, bit 0 set when on any axis the mean of
//     the five newest samples differs from the mean of the five before them
//     by more than jump_threshold.
//   cfg channel: writes jump_threshold (always ready). Write only while idle.
// Timing:
//   Accept updates the per-axis shift line and running sums (stage 1); the
//   next advance compares and loads the output register, and m_tvalid rises
//   with that load (two register stages); one word per cycle sustained while
//   m_tready is high.
//   Each sum moves by one add/subtract per sample, so the compare is a single
//   subtract, magnitude and compare against 5 * threshold.
// Reset:
//   History and sums clear to zero (missing samples count as zero), threshold
//   returns to 512 (0.5 g), both pipeline stages empty.
// Stall:
//   While m_tready is low the output word holds; stage 1 can still take one
//   more sample, after which s_tready drops until the output drains.
module accel_jump_detector_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [13:0] accel_x, [27:14] accel_y, [41:28] accel_z, rest zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ajd_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [0] jump_detected, rest zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ajd_pkg::M_TDATA_W-1:0] m_tdata,
    // jump_threshold write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  ajd_pkg::thresh_t              cfg_data
);
    import ajd_pkg::*;

    limit_t  limit_reg;            // 5 * threshold, kept ready for compare
    logic    st1_valid_reg;        // sums hold a sample not yet compared
    logic    m_valid_reg;
    logic    jump_reg;
    logic    advance;
    logic    s_accept;
    logic [NUM_AXES-1:0] axis_exceed;
    sample_t axis_sample [NUM_AXES];

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = advance || !st1_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            axis_sample[a] = sample_t'(s_tdata[a*SAMPLE_W +: SAMPLE_W]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_axis
            ajd_axis_window u_axis (
                .aclk    (aclk),
                .aresetn (aresetn),
                .load    (s_accept),
                .sample  (axis_sample[g]),
                .limit   (limit_reg),
                .exceed  (axis_exceed[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= limit_of(THRESH_RESET);
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= limit_of(cfg_data);
            end
            if (s_accept) begin
                st1_valid_reg <= 1'b1;
            end else if (advance) begin
                st1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            jump_reg <= |axis_exceed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 1)'(0), jump_reg};

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> st1_valid_reg && m_valid_reg)
        else $error("input blocked with a free stage");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !advance |=> st1_valid_reg)
        else $error("stage 1 word lost under stall");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && advance |=> m_valid_reg)
        else $error("stage 1 word not passed to output");

    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> limit_reg == limit_of($past(cfg_data)))
        else $error("limit not updated from threshold write");

endmodule

@@ rtl/core/ajd_axis_window.sv @@
// One axis: sample shift line, running window sums and the threshold compare.
`timescale 1ns / 1ps
module ajd_axis_window (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ajd_pkg::sample_t sample,
    input  ajd_pkg::limit_t  limit,
    output logic             exceed
);
    import ajd_pkg::*;

    sample_t hist_reg [RING_DEPTH];   // index 0 = newest
    sum_t    recent_reg, recent_next;
    sum_t    older_reg, older_next;
    diff_t   diff;
    logic [CMP_W-1:0] diff_mag;
    sum_t    chk_recent, chk_older;

    // sample leaving the recent window enters the older one
    always_comb begin
        recent_next = recent_reg + SUM_W'(sample) - SUM_W'(hist_reg[WINDOW-1]);
        older_next  = older_reg + SUM_W'(hist_reg[WINDOW-1])
                      - SUM_W'(hist_reg[RING_DEPTH-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            recent_reg <= '0;
            older_reg  <= '0;
        end else if (load) begin
            hist_reg[0] <= sample;
            for (int i = 1; i < RING_DEPTH; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            recent_reg <= recent_next;
            older_reg  <= older_next;
        end
    end

    always_comb begin
        diff     = DIFF_W'(recent_reg) - DIFF_W'(older_reg);
        diff_mag = diff[DIFF_W-1] ? CMP_W'(-diff) : CMP_W'(diff);
        exceed   = diff_mag > CMP_W'(limit);
    end

    // full recount of the taps, for checking only
    always_comb begin
        chk_recent = '0;
        chk_older  = '0;
        for (int i = 0; i < WINDOW; i++) begin
            chk_recent = chk_recent + SUM_W'(hist_reg[i]);
            chk_older  = chk_older + SUM_W'(hist_reg[WINDOW+i]);
        end
    end

    a_recent_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        recent_reg == chk_recent) else $error("recent window sum drifted");

    a_older_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        older_reg == chk_older) else $error("older window sum drifted");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> $stable(recent_reg) && $stable(older_reg))
        else $error("sums moved without a load");

endmodule

@@ sim/accel_jump_detector_core_tb.sv @@
// Self-checking testbench for the accelerometer jump detector core.
`timescale 1ns / 1ps
module accel_jump_detector_core_tb;
    import ajd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct packed {
        sample_t z;
        sample_t y;
        sample_t x;
    } accel_word_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    thresh_t              cfg_data  = '0;

    // predictor state: sample ring, next slot, threshold
    sample_t     ring [RING_DEPTH][NUM_AXES];
    int          ring_pos;
    thresh_t     jump_threshold;

    accel_word_t word_pending_q [$];
    logic        jump_expect_q [$];
    accel_word_t word_on_bus;
    int          src_gap, sink_gap;
    int          src_gap_pct, sink_gap_pct;
    int          mismatch_count;
    int unsigned cycle_count;

    accel_jump_detector_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Write one sample into the ring, then compare newest-five vs older-five sums.
    function automatic logic advance_history(input accel_word_t w);
        int   recent, older, diff, limit, slot;
        logic jump;
        ring[ring_pos][0] = w.x;
        ring[ring_pos][1] = w.y;
        ring[ring_pos][2] = w.z;
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        limit = WINDOW * int'(jump_threshold);
        jump = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            recent = 0;
            older = 0;
            for (int age = 0; age < RING_DEPTH; age++) begin
                slot = (ring_pos + RING_DEPTH - 1 - age) % RING_DEPTH;
                if (age < WINDOW)
                    recent += int'(ring[slot][a]);
                else
                    older += int'(ring[slot][a]);
            end
            diff = recent - older;
            if (diff < 0)
                diff = -diff;
            if (diff > limit)
                jump = 1'b1;
        end
        return jump;
    endfunction

    function automatic sample_t clamp_sample(input int v);
        if (v > 8191)
            return sample_t'(8191);
        if (v < -8192)
            return sample_t'(-8192);
        return sample_t'(v);
    endfunction

    task automatic push_word(input int x, input int y, input int z);
        accel_word_t w;
        w.x = clamp_sample(x);
        w.y = clamp_sample(y);
        w.z = clamp_sample(z);
        word_pending_q.push_back(w);
    endtask

    // Mostly step sequences (flat run, step near threshold on one axis, flat run),
    // the rest raw random words.
    task automatic add_random_words(input int count);
        int          made, run_len, amp, ax, delta, noise;
        int          level [NUM_AXES];
        int          v [NUM_AXES];
        accel_word_t w;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 4) == 0) begin
                run_len = $urandom_range(1, 12);
                for (int i = 0; i < run_len; i++) begin
                    w.x = sample_t'($urandom_range(0, 16383));
                    w.y = sample_t'($urandom_range(0, 16383));
                    w.z = sample_t'($urandom_range(0, 16383));
                    word_pending_q.push_back(w);
                end
                made += run_len;
            end else begin
                amp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                for (int a = 0; a < NUM_AXES; a++) begin
                    level[a] = $urandom_range(0, 12000);
                    level[a] -= 6000;
                end
                ax = $urandom_range(0, NUM_AXES - 1);
                delta = $urandom_range(0, 6);
                delta = delta - 3 + int'(jump_threshold);
                if ($urandom_range(0, 1) == 1)
                    delta = -delta;
                for (int half = 0; half < 2; half++) begin
                    run_len = $urandom_range(6, 16);
                    for (int i = 0; i < run_len; i++) begin
                        for (int a = 0; a < NUM_AXES; a++) begin
                            noise = $urandom_range(0, 2 * amp);
                            v[a] = level[a] + noise - amp;
                        end
                        push_word(v[0], v[1], v[2]);
                    end
                    made += run_len;
                    level[ax] += delta;
                end
            end
        end
    endtask

    // Waits until all words are accepted and answered by the 2-stage pipe.
    task automatic wait_drained();
        while (word_pending_q.size() != 0 || s_tvalid || jump_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(input thresh_t value);
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        jump_threshold = value;
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready)
                jump_expect_q.push_back(advance_history(word_on_bus));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (word_pending_q.size() != 0) begin
                    word_on_bus = word_pending_q.pop_front();
                    s_tdata  <= S_TDATA_W'(word_on_bus);
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 99) < src_gap_pct)
                        src_gap <= $urandom_range(1, 18);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (jump_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    logic jump_want;
                    jump_want = jump_expect_q.pop_front();
                    if (m_tdata !== M_TDATA_W'(jump_want)) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("jump_detected mismatch: expected %h actual %h",
                                     M_TDATA_W'(jump_want), m_tdata);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < sink_gap_pct)
                    sink_gap <= $urandom_range(1, 18);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        thresh_t thr_plan [7];
        ring_pos       = 0;
        jump_threshold = THRESH_RESET;
        mismatch_count = 0;
        cycle_count    = 0;
        src_gap_pct    = 10;
        sink_gap_pct   = 10;
        for (int i = 0; i < RING_DEPTH; i++)
            for (int a = 0; a < NUM_AXES; a++)
                ring[i][a] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Ring still filling; fifth word sits exactly on the limit (not a jump).
        for (int i = 0; i < 5; i++)
            push_word(512, 0, 0);
        push_word(513, 0, 0);
        push_word(8191, 8191, 8191);
        push_word(-8192, -8192, -8192);
        push_word(-8192, -8192, -8192);
        push_word(0, -8192, 0);
        push_word(0, 0, 8191);
        for (int i = 0; i < 5; i++)
            push_word(0, -512, 0);
        for (int i = 0; i < 5; i++)
            push_word(0, 0, 600);
        add_random_words(230);
        wait_drained();

        thr_plan[0] = '0;
        thr_plan[1] = thresh_t'(8191);
        thr_plan[2] = thresh_t'(1);
        thr_plan[3] = thresh_t'(37);
        thr_plan[4] = thresh_t'($urandom_range(0, 8191));
        thr_plan[5] = thresh_t'(2048);
        thr_plan[6] = THRESH_RESET;
        for (int p = 0; p < 7; p++) begin
            write_threshold(thr_plan[p]);
            if (p == 6) begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end else begin
                src_gap_pct  = $urandom_range(0, 30);
                sink_gap_pct = $urandom_range(0, 30);
            end
            add_random_words(230);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && jump_expect_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ajd_pkg.sv
rtl/core/ajd_axis_window.sv
rtl/core/accel_jump_detector_core.sv
sim/accel_jump_detector_core_tb.sv
